// File: src/vldc_pkg.sv
package vldc_pkg;

    // Pixels stored per captured row
    localparam int ROW_PIXELS = 128;

    // Event codes on req_type
    localparam logic [1:0] REQ_VSYNC = 2'd0;
    localparam logic [1:0] REQ_HSYNC = 2'd1;
    localparam logic [1:0] REQ_PIXEL = 2'd2;

    // Write kinds on write_kind
    localparam logic [1:0] WR_PIXEL = 2'd0;
    localparam logic [1:0] WR_READY = 2'd1;
    localparam logic [1:0] WR_FRAME = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_FIRST_LINE  = 2'd0;
    localparam logic [1:0] CFG_STOP_LINE   = 2'd1;
    localparam logic [1:0] CFG_LINE_STEP   = 2'd2;
    localparam logic [1:0] CFG_SKIP_PIXELS = 2'd3;

    // Configuration reset values
    localparam logic [15:0] FIRST_LINE_RST  = 16'd90;
    localparam logic [15:0] STOP_LINE_RST   = 16'd290;
    localparam logic [7:0]  LINE_STEP_RST   = 8'd5;
    localparam logic [5:0]  SKIP_PIXELS_RST = 6'd6;

    localparam logic [7:0] READY_BYTE = 8'hff;
    localparam logic [7:0] MAX_ROWS   = 8'd255;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] pixel;
    } t_in;

    typedef struct packed {
        logic [1:0] write_kind;
        logic       buffer_sel;
        logic [7:0] row_index;
        logic [6:0] column_index;
        logic [7:0] write_value;
        logic       last;
    } t_out;

endpackage

// File: src/video_line_decimating_capture_unit.sv
// Line-decimating frame grabber front end.
// Input channel (i_in_valid / o_in_ready / i_in_data): one video event per
// transaction: vertical sync, horizontal sync or a pixel byte.
// Output channel (o_out_valid / i_out_ready / o_out_data): memory writes into
// two ping-pong frame buffers; 'last' marks the final write caused by an event.
// Config port (i_cfg_we / i_cfg_index / i_cfg_data): register writes take
// effect on the next clock; write only while the block is idle.
// Timing: an event is evaluated in the cycle it is accepted; its first write
// is presented on the next cycle, the remaining ones one per cycle after while
// the receiver accepts. Throughput: one event per cycle while each event causes
// at most one write and the receiver accepts. A vertical sync causes three writes,
// the last pixel of a row two, as the 3-entry result queue drains one per cycle.
// Reset (synchronous, active low) clears the counters, the frame number and
// the queue, and loads the default window of lines 90 to 289 (stop line 290), step 5, skip 6.
// When the receiver stalls the queue holds; a new event is taken only when
// the queue is empty or its final write leaves in the same cycle.
module video_line_decimating_capture_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vldc_pkg::t_in       i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vldc_pkg::t_out      o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    logic [15:0] r_first_line;
    logic [15:0] r_stop_line;
    logic [7:0]  r_line_step;
    logic [5:0]  r_skip_pixels;

    logic [15:0] r_line_count,     n_line_count;
    logic [7:0]  r_frame_number,   n_frame_number;
    logic [7:0]  r_step_phase,     n_step_phase;
    logic [7:0]  r_captured_rows,  n_captured_rows;
    logic        r_capture_armed,  n_capture_armed;
    logic [7:0]  r_current_row,    n_current_row;
    logic [7:0]  r_pixel_position, n_pixel_position;

    vldc_pkg::t_out r_res [3];
    vldc_pkg::t_out n_res [3];
    logic [1:0]     r_cnt;
    logic [1:0]     n_num;

    logic in_acc;
    logic out_acc;

    // hsync helpers
    logic       at_first;
    logic [7:0] phase_eff;
    logic [7:0] rows_eff;
    logic [8:0] phase_inc;
    // pixel helpers
    logic [7:0] col;
    logic [8:0] col_inc;
    logic [7:0] frame_inc;

    assign o_in_ready  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_res[0];
    assign out_acc     = o_out_valid && i_out_ready;

    assign at_first  = (r_line_count == r_first_line);
    assign phase_eff = at_first ? 8'd0 : r_step_phase;
    assign rows_eff  = at_first ? 8'd0 : r_captured_rows;
    assign phase_inc = {1'b0, phase_eff} + 9'd1;
    assign col       = r_pixel_position - {2'b00, r_skip_pixels};
    assign col_inc   = {1'b0, col} + 9'd1;
    assign frame_inc = r_frame_number + 8'd1;

    always_comb begin
        n_line_count     = r_line_count;
        n_frame_number   = r_frame_number;
        n_step_phase     = r_step_phase;
        n_captured_rows  = r_captured_rows;
        n_capture_armed  = r_capture_armed;
        n_current_row    = r_current_row;
        n_pixel_position = r_pixel_position;
        n_num            = 2'd0;
        for (int k = 0; k < 3; k++) begin
            n_res[k] = '0;
        end

        unique case (i_in_data.req_type)
            vldc_pkg::REQ_VSYNC: begin
                n_res[0].write_kind  = vldc_pkg::WR_READY;
                n_res[0].buffer_sel  = r_frame_number[0];
                n_res[0].write_value = vldc_pkg::READY_BYTE;
                n_res[1].write_kind  = vldc_pkg::WR_FRAME;
                n_res[1].buffer_sel  = frame_inc[0];
                n_res[1].write_value = frame_inc;
                n_res[2].write_kind  = vldc_pkg::WR_READY;
                n_res[2].buffer_sel  = frame_inc[0];
                n_res[2].last        = 1'b1;
                n_num                = 2'd3;
                n_frame_number       = frame_inc;
                n_line_count         = '0;
                n_step_phase         = '0;
                n_captured_rows      = '0;
                n_capture_armed      = 1'b0;
                n_pixel_position     = '0;
            end
            vldc_pkg::REQ_HSYNC: begin
                n_capture_armed  = 1'b0;
                n_pixel_position = '0;
                n_step_phase     = phase_eff;
                n_captured_rows  = rows_eff;
                if ((r_line_count >= r_first_line) && (r_line_count < r_stop_line) &&
                    (phase_eff == 8'd0) && (rows_eff < vldc_pkg::MAX_ROWS)) begin
                    n_capture_armed = 1'b1;
                    n_current_row   = rows_eff;
                    n_captured_rows = rows_eff + 8'd1;
                end
                if (r_line_count >= r_first_line) begin
                    // zero step compares true here, so it behaves as step 1
                    n_step_phase = (phase_inc >= {1'b0, r_line_step}) ? 8'd0
                                                                      : phase_inc[7:0];
                end
                n_line_count = r_line_count + 16'd1;
            end
            vldc_pkg::REQ_PIXEL: begin
                if (r_capture_armed) begin
                    n_pixel_position = r_pixel_position + 8'd1;
                    if (r_pixel_position >= {2'b00, r_skip_pixels}) begin
                        n_res[0].write_kind   = vldc_pkg::WR_PIXEL;
                        n_res[0].buffer_sel   = r_frame_number[0];
                        n_res[0].row_index    = r_current_row;
                        n_res[0].column_index = col[6:0];
                        n_res[0].write_value  = i_in_data.pixel;
                        if (col_inc >= 9'(vldc_pkg::ROW_PIXELS)) begin
                            // row complete: ready byte carries the row number
                            n_res[1].write_kind  = vldc_pkg::WR_READY;
                            n_res[1].buffer_sel  = r_frame_number[0];
                            n_res[1].write_value = r_current_row;
                            n_res[1].last        = 1'b1;
                            n_num                = 2'd2;
                            n_capture_armed      = 1'b0;
                            n_pixel_position     = '0;
                        end else begin
                            n_res[0].last = 1'b1;
                            n_num         = 2'd1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_line     <= vldc_pkg::FIRST_LINE_RST;
            r_stop_line      <= vldc_pkg::STOP_LINE_RST;
            r_line_step      <= vldc_pkg::LINE_STEP_RST;
            r_skip_pixels    <= vldc_pkg::SKIP_PIXELS_RST;
            r_line_count     <= '0;
            r_frame_number   <= '0;
            r_step_phase     <= '0;
            r_captured_rows  <= '0;
            r_capture_armed  <= 1'b0;
            r_current_row    <= '0;
            r_pixel_position <= '0;
            r_cnt            <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    vldc_pkg::CFG_FIRST_LINE:  r_first_line  <= i_cfg_data;
                    vldc_pkg::CFG_STOP_LINE:   r_stop_line   <= i_cfg_data;
                    vldc_pkg::CFG_LINE_STEP:   r_line_step   <= i_cfg_data[7:0];
                    vldc_pkg::CFG_SKIP_PIXELS: r_skip_pixels <= i_cfg_data[5:0];
                    default: begin
                    end
                endcase
            end
            if (in_acc) begin
                r_line_count     <= n_line_count;
                r_frame_number   <= n_frame_number;
                r_step_phase     <= n_step_phase;
                r_captured_rows  <= n_captured_rows;
                r_capture_armed  <= n_capture_armed;
                r_current_row    <= n_current_row;
                r_pixel_position <= n_pixel_position;
                r_cnt            <= n_num;
            end else if (out_acc) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // result queue payload; head is entry 0
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int k = 0; k < 3; k++) begin
                r_res[k] <= n_res[k];
            end
        end else if (out_acc) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

endmodule
